[hdl/qpac_pkg.sv]
// ---------------------------------------------------------------------------
// qpac_pkg
// shared types and constants of the quaternion pid attitude controller
// ---------------------------------------------------------------------------
package qpac_pkg;

    localparam int QUAT_W   = 16;
    localparam int QUAT_FRAC = 14;
    localparam int PROD_W   = 32;
    localparam int VEC_W    = 34;
    localparam int REG_W    = 31;
    localparam int DATA_W   = 32;
    localparam int IDX_W    = 3;
    localparam int CNT_W    = 4;

    localparam logic [REG_W-1:0] LIMIT_RST = 31'd3276800;
    localparam logic [REG_W-1:0] STEP_RST  = 31'd655;

    localparam logic [IDX_W-1:0] REG_PROP_GAIN  = 3'd0;
    localparam logic [IDX_W-1:0] REG_INT_GAIN   = 3'd1;
    localparam logic [IDX_W-1:0] REG_RATE_GAIN  = 3'd2;
    localparam logic [IDX_W-1:0] REG_INT_LIMIT  = 3'd3;
    localparam logic [IDX_W-1:0] REG_TIME_STEP  = 3'd4;

    // pipeline count at which the integral is updated and the last one
    localparam logic [CNT_W-1:0] CNT_INT  = 4'd5;
    localparam logic [CNT_W-1:0] CNT_LAST = 4'd8;

    typedef enum logic [0:0] {
        S_IDLE,
        S_RUN
    } t_state;

    typedef struct packed {
        logic int_we;
    } t_lane_ctrl;

    typedef struct packed {
        logic [REG_W-1:0] prop_gain;
        logic [REG_W-1:0] int_gain;
        logic [REG_W-1:0] rate_gain;
        logic [REG_W-1:0] int_limit;
        logic [REG_W-1:0] time_step;
    } t_cfg;

endpackage

[hdl/qpac_qlane.sv]
// ---------------------------------------------------------------------------
// qpac_qlane
// one component of the quaternion product: four products and a signed sum
// ---------------------------------------------------------------------------
module qpac_qlane #(
    parameter logic [3:0] NEG = 4'b0000
) (
    input  logic                               i_clk,
    input  logic signed [qpac_pkg::QUAT_W-1:0] i_a [4],
    input  logic signed [qpac_pkg::QUAT_W-1:0] i_b [4],
    output logic signed [qpac_pkg::VEC_W-1:0]  o_sum
);
    import qpac_pkg::*;

    logic signed [PROD_W-1:0] r_prod [4];
    logic signed [VEC_W-1:0]  n_sum;
    logic signed [VEC_W-1:0]  r_sum;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            r_prod[i] <= i_a[i] * i_b[i];
        end
        r_sum <= n_sum;
    end

    always_comb begin
        n_sum = '0;
        for (int i = 0; i < 4; i++) begin
            if (NEG[i]) begin
                n_sum = n_sum - VEC_W'(r_prod[i]);
            end else begin
                n_sum = n_sum + VEC_W'(r_prod[i]);
            end
        end
    end

    assign o_sum = r_sum;

endmodule

[hdl/qpac_axis.sv]
// ---------------------------------------------------------------------------
// qpac_axis
// one axis: error scaling, integral update with clamp, pid sum, saturation
// ---------------------------------------------------------------------------
module qpac_axis #(
    parameter int FRAC_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  qpac_pkg::t_lane_ctrl               i_ctrl,
    input  qpac_pkg::t_cfg                     i_cfg,
    input  logic signed [qpac_pkg::VEC_W-1:0]  i_v,
    input  logic signed [qpac_pkg::DATA_W-1:0] i_rate,
    output logic signed [qpac_pkg::DATA_W-1:0] o_torque
);
    import qpac_pkg::*;

    localparam int ESH = 2 * QUAT_FRAC - 1 - FRAC_BITS;
    localparam int EW  = VEC_W - ESH;
    localparam int MW  = EW + DATA_W;
    localparam int AW  = MW - FRAC_BITS + 1;
    localparam int PW  = 64;
    localparam int SW  = PW + 2;

    logic signed [EW-1:0]     r_e;
    logic signed [MW-1:0]     r_eprod;
    logic signed [DATA_W-1:0] r_int;
    logic signed [DATA_W-1:0] r_acc;
    logic signed [AW-1:0]     n_acc;
    logic signed [AW-1:0]     lim;
    logic signed [DATA_W-1:0] n_clamp;
    logic signed [PW-1:0]     r_pp, r_pi, r_pr;
    logic signed [SW-1:0]     sum;
    logic signed [SW-1:0]     shifted;
    logic signed [DATA_W-1:0] n_torque;
    logic signed [DATA_W-1:0] r_torque;

    always_comb begin
        lim   = signed'(AW'(i_cfg.int_limit));
        n_acc = AW'(r_int) + AW'(r_eprod >>> FRAC_BITS);
        if (n_acc > lim) begin
            n_clamp = DATA_W'(lim);
        end else if (n_acc < -lim) begin
            n_clamp = DATA_W'(-lim);
        end else begin
            n_clamp = DATA_W'(n_acc);
        end
    end

    // torque = -(kp*e + ki*i) + kd*rate, floored at the fraction point
    always_comb begin
        sum     = SW'(r_pr) - SW'(r_pp) - SW'(r_pi);
        shifted = sum >>> FRAC_BITS;
        if (shifted > SW'(32'sh7fffffff)) begin
            n_torque = 32'sh7fffffff;
        end else if (shifted < SW'(-33'sh80000000)) begin
            n_torque = -32'sh80000000;
        end else begin
            n_torque = DATA_W'(shifted);
        end
    end

    always_ff @(posedge i_clk) begin
        r_e     <= EW'(i_v >>> ESH);
        r_eprod <= MW'(r_e) * MW'(signed'({1'b0, i_cfg.time_step}));
        if (i_ctrl.int_we) begin
            r_acc <= n_clamp;
        end
        r_pp     <= PW'(signed'({1'b0, i_cfg.prop_gain})) * PW'(r_e);
        r_pi     <= PW'(signed'({1'b0, i_cfg.int_gain})) * PW'(r_acc);
        r_pr     <= PW'(signed'({1'b0, i_cfg.rate_gain})) * PW'(i_rate);
        r_torque <= n_torque;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_int <= '0;
        end else if (i_ctrl.int_we) begin
            r_int <= n_clamp;
        end
    end

    assign o_torque = r_torque;

endmodule

[hdl/quaternion_pid_attitude_control.sv]
// ---------------------------------------------------------------------------
// quaternion_pid_attitude_control
// quaternion error pid attitude controller, fixed point
// ---------------------------------------------------------------------------
// One transaction in, one torque transaction out. An accepted item passes from
// the capture register through the quaternion product lanes, the three axis
// lanes (one multiplier stage for e*dt, one for the three gain products, then
// the saturating torque register) and the merge into the output register. The
// block handles one item at a time, so a new item is taken only after the
// previous result has been loaded into the output register; a finished result
// may wait in the output register while the next item is already accepted.
// Configuration writes are always ready and only meant while no item is in
// flight.
module quaternion_pid_attitude_control #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [qpac_pkg::QUAT_W-1:0]  i_target_w,
    input  logic signed [qpac_pkg::QUAT_W-1:0]  i_target_x,
    input  logic signed [qpac_pkg::QUAT_W-1:0]  i_target_y,
    input  logic signed [qpac_pkg::QUAT_W-1:0]  i_target_z,
    input  logic signed [qpac_pkg::QUAT_W-1:0]  i_current_w,
    input  logic signed [qpac_pkg::QUAT_W-1:0]  i_current_x,
    input  logic signed [qpac_pkg::QUAT_W-1:0]  i_current_y,
    input  logic signed [qpac_pkg::QUAT_W-1:0]  i_current_z,
    input  logic signed [qpac_pkg::DATA_W-1:0]  i_rate_x,
    input  logic signed [qpac_pkg::DATA_W-1:0]  i_rate_y,
    input  logic signed [qpac_pkg::DATA_W-1:0]  i_rate_z,
    // output channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [qpac_pkg::DATA_W-1:0]  o_torque_x,
    output logic signed [qpac_pkg::DATA_W-1:0]  o_torque_y,
    output logic signed [qpac_pkg::DATA_W-1:0]  o_torque_z,
    // configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [qpac_pkg::IDX_W-1:0]          i_cfg_index,
    input  logic [qpac_pkg::DATA_W-1:0]         i_cfg_data
);
    import qpac_pkg::*;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt;
    t_cfg             r_cfg;
    logic             in_acc;
    logic             out_free;
    logic             load_out;
    t_lane_ctrl       ctrl;

    // captured transaction
    logic signed [QUAT_W-1:0] r_cq [4];
    logic signed [QUAT_W-1:0] r_tq [4];
    logic signed [DATA_W-1:0] r_rate [3];

    // quaternion product lanes: w, x, y, z of conj(current) * target
    logic signed [QUAT_W-1:0] b_w [4], b_x [4], b_y [4], b_z [4];
    logic signed [VEC_W-1:0]  qw, qx, qy, qz;
    logic signed [VEC_W-1:0]  r_v [3];
    logic signed [DATA_W-1:0] torque [3];

    logic signed [DATA_W-1:0] r_out [3];
    logic                     r_out_valid;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign load_out    = (r_state == S_RUN) && (r_cnt == CNT_LAST) && out_free;
    assign o_cfg_ready = 1'b1;

    // config registers, bits above the register width are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop_gain <= '0;
            r_cfg.int_gain  <= '0;
            r_cfg.rate_gain <= '0;
            r_cfg.int_limit <= LIMIT_RST;
            r_cfg.time_step <= STEP_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_PROP_GAIN: r_cfg.prop_gain <= i_cfg_data[REG_W-1:0];
                REG_INT_GAIN:  r_cfg.int_gain  <= i_cfg_data[REG_W-1:0];
                REG_RATE_GAIN: r_cfg.rate_gain <= i_cfg_data[REG_W-1:0];
                REG_INT_LIMIT: r_cfg.int_limit <= i_cfg_data[REG_W-1:0];
                REG_TIME_STEP: r_cfg.time_step <= i_cfg_data[REG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // sequencer: next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) n_state = S_RUN;
            end
            S_RUN: begin
                if (load_out) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer: outputs
    always_comb begin
        o_in_stall  = 1'b1;
        ctrl.int_we = 1'b0;
        unique case (r_state)
            S_IDLE:  o_in_stall = 1'b0;
            S_RUN:   ctrl.int_we = (r_cnt == CNT_INT);
            default: o_in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (in_acc) begin
                r_cnt <= '0;
            end else if (r_state == S_RUN && r_cnt != CNT_LAST) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // capture the transaction
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cq[0]   <= i_current_w;
            r_cq[1]   <= i_current_x;
            r_cq[2]   <= i_current_y;
            r_cq[3]   <= i_current_z;
            r_tq[0]   <= i_target_w;
            r_tq[1]   <= i_target_x;
            r_tq[2]   <= i_target_y;
            r_tq[3]   <= i_target_z;
            r_rate[0] <= i_rate_x;
            r_rate[1] <= i_rate_y;
            r_rate[2] <= i_rate_z;
        end
    end

    // operand order of the target per product lane
    assign b_w = '{r_tq[0], r_tq[1], r_tq[2], r_tq[3]};
    assign b_x = '{r_tq[1], r_tq[0], r_tq[3], r_tq[2]};
    assign b_y = '{r_tq[2], r_tq[3], r_tq[0], r_tq[1]};
    assign b_z = '{r_tq[3], r_tq[2], r_tq[1], r_tq[0]};

    qpac_qlane #(.NEG(4'b0000)) u_qw (.i_clk(i_clk), .i_a(r_cq), .i_b(b_w), .o_sum(qw));
    qpac_qlane #(.NEG(4'b0110)) u_qx (.i_clk(i_clk), .i_a(r_cq), .i_b(b_x), .o_sum(qx));
    qpac_qlane #(.NEG(4'b1100)) u_qy (.i_clk(i_clk), .i_a(r_cq), .i_b(b_y), .o_sum(qy));
    qpac_qlane #(.NEG(4'b1010)) u_qz (.i_clk(i_clk), .i_a(r_cq), .i_b(b_z), .o_sum(qz));

    // shortest rotation: flip the vector part when the scalar is negative
    always_ff @(posedge i_clk) begin
        if (qw < 0) begin
            r_v[0] <= -qx;
            r_v[1] <= -qy;
            r_v[2] <= -qz;
        end else begin
            r_v[0] <= qx;
            r_v[1] <= qy;
            r_v[2] <= qz;
        end
    end

    // one axis lane per body axis
    for (genvar g = 0; g < 3; g++) begin : g_axis
        qpac_axis #(.FRAC_BITS(FRAC_BITS)) u_axis (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctrl   (ctrl),
            .i_cfg    (r_cfg),
            .i_v      (r_v[g]),
            .i_rate   (r_rate[g]),
            .o_torque (torque[g])
        );
    end

    // merge the lanes into one result transaction
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out[0] <= torque[0];
            r_out[1] <= torque[1];
            r_out[2] <= torque[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_torque_x  = r_out[0];
    assign o_torque_y  = r_out[1];
    assign o_torque_z  = r_out[2];

endmodule
